// File: design/pfa_pkg.sv
// shared constants, codes and the result record of the partition fit allocator
package pfa_pkg;

	localparam int SLOTS_DEF       = 4;
	localparam int OFFSET_BITS_DEF = 31;

	localparam int AMT_W   = 32;
	localparam int SIZE_W  = 31;
	localparam int BASE_W  = 12;
	localparam int IDX_W   = 2;
	localparam int STAT_W  = 3;
	localparam int CODE_W  = 2;

	localparam int KIB_SHIFT = 10;
	localparam int MIB_SHIFT = 20;

	// actions
	localparam logic [CODE_W-1:0] ACT_PLACE = 2'd0;
	localparam logic [CODE_W-1:0] ACT_GROW  = 2'd1;
	localparam logic [CODE_W-1:0] ACT_READ  = 2'd2;

	// size units
	localparam logic [CODE_W-1:0] UNIT_B   = 2'd0;
	localparam logic [CODE_W-1:0] UNIT_KIB = 2'd1;
	localparam logic [CODE_W-1:0] UNIT_MIB = 2'd2;

	// fit modes
	localparam logic [CODE_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [CODE_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [CODE_W-1:0] FIT_WORST = 2'd2;

	// register indexes
	localparam logic [CODE_W-1:0] REG_DISK_SIZE  = 2'd0;
	localparam logic [CODE_W-1:0] REG_FIT_MODE   = 2'd1;
	localparam logic [CODE_W-1:0] REG_TABLE_BASE = 2'd2;

	localparam logic [SIZE_W-1:0] DISK_SIZE_RST  = '0;
	localparam logic [CODE_W-1:0] FIT_MODE_RST   = FIT_BEST;
	localparam logic [BASE_W-1:0] TABLE_BASE_RST = 12'd128;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] ST_EXT_TWICE = 3'd3;
	localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd4;
	localparam logic [STAT_W-1:0] ST_NO_SLOT   = 3'd5;
	localparam logic [STAT_W-1:0] ST_OVER      = 3'd6;
	localparam logic [STAT_W-1:0] ST_UNCHANGED = 3'd7;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  slot;
		logic [SIZE_W-1:0] start;
		logic [SIZE_W-1:0] size;
		logic              valid;
		logic              ext;
	} res_t;

endpackage

// File: design/partition_fit_allocator.sv
// partition fit allocator: sorted region table with first, best and worst fit placement
//
// Usage: software writes disk_size, fit_mode and table_base through cfg_we, cfg_addr and
// cfg_data while the block is idle. A command (action, amount, size_unit, region_kind,
// slot_index) is taken at a clock edge with start high and busy low. Exactly one result
// follows: done is high for one cycle with status, result_slot, region_start,
// region_size, region_valid and region_extended, and the receiver must take it then.
// busy is low again in the cycle that done is high, so the next command may start there.
// Command flow: a read, an unknown action or a request refused straight away finishes
// from idle; a grow passes S_GROW_A and then S_GROW_B, or ends in S_GROW_A when the new
// size would be nothing; a place with no fitting gap ends after scanning the valid
// regions, and a place that fits scans them and then moves regions up in S_SHIFT to
// make room before it finishes.
// A place steps one gap subtractor and compare through the regions one per cycle, then
// moves one region per cycle for the insertion.
// Reset empties the table and loads disk_size 0, best fit and table_base 128.
// One command is worked on at a time.
module partition_fit_allocator #(
	parameter int SLOTS       = pfa_pkg::SLOTS_DEF,
	parameter int OFFSET_BITS = pfa_pkg::OFFSET_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pfa_pkg::CODE_W-1:0]        cfg_addr,
	input  logic [pfa_pkg::SIZE_W-1:0]        cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic [pfa_pkg::CODE_W-1:0]        action,
	input  logic signed [pfa_pkg::AMT_W-1:0]  amount,
	input  logic [pfa_pkg::CODE_W-1:0]        size_unit,
	input  logic                              region_kind,
	input  logic [pfa_pkg::IDX_W-1:0]         slot_index,
	output logic                              done,
	output logic [pfa_pkg::STAT_W-1:0]        status,
	output logic [pfa_pkg::IDX_W-1:0]         result_slot,
	output logic [pfa_pkg::SIZE_W-1:0]        region_start,
	output logic [pfa_pkg::SIZE_W-1:0]        region_size,
	output logic                              region_valid,
	output logic                              region_extended
);
	import pfa_pkg::*;

	localparam int SI  = $clog2(SLOTS);
	localparam int OB  = OFFSET_BITS;
	localparam int OW  = (OB > SIZE_W) ? OB : SIZE_W;
	localparam int PW  = OW + 3;
	localparam int SZW = AMT_W - 1 + MIB_SHIFT;
	localparam int DW  = ((OB > SZW) ? OB : SZW) + 4;
	localparam logic [SI-1:0] LAST_IDX = SI'(SLOTS - 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_SHIFT  = 5'b00100,
		S_GROW_A = 5'b01000,
		S_GROW_B = 5'b10000
	} state_t;

	function automatic logic [SIZE_W-1:0] out_w(input logic [OB-1:0] v);
		logic [OW-1:0] t;
		t = OW'(v);
		return t[SIZE_W-1:0];
	endfunction

	function automatic res_t pack_res(input logic [STAT_W-1:0] st, input logic [SI-1:0] idx,
			input logic [OB-1:0] s, input logic [OB-1:0] z, input logic v, input logic e);
		res_t r;
		r.status = st;
		r.slot   = IDX_W'(idx);
		r.start  = v ? out_w(s) : '0;
		r.size   = v ? out_w(z) : '0;
		r.valid  = v;
		r.ext    = v & e;
		return r;
	endfunction

	function automatic res_t res_fail(input logic [STAT_W-1:0] st);
		return pack_res(st, '0, '0, '0, 1'b0, 1'b0);
	endfunction

	// configuration
	logic [SIZE_W-1:0] disk_q;
	logic [CODE_W-1:0] fit_q;
	logic [BASE_W-1:0] tbase_q;

	// region table
	logic [SLOTS-1:0]  valid_q;
	logic [SLOTS-1:0]  ext_q;
	logic [OB-1:0]     start_q [SLOTS];
	logic [OB-1:0]     size_q  [SLOTS];

	// sequencer and working registers
	state_t            state_q, state_d;
	logic              done_q;
	res_t              res_q;
	logic [SI-1:0]     i_q, j_q, k_q;
	logic [OB-1:0]     sz_q;
	logic              kind_q;
	logic signed [PW-1:0] base_q, best_left_q;
	logic [OB-1:0]     best_start_q;
	logic              found_q;
	logic signed [DW-1:0] delta_q, nsz_q;
	logic [OB-1:0]     gstart_q;

	// shared read port of the table
	logic [SI-1:0]     rd_addr;
	logic [OB-1:0]     rd_start, rd_size;
	logic              rd_valid, rd_ext;

	logic [4:0]        sh_c;
	logic              unit_ok, amt_pos, over_c, idx_ok;
	logic [SI-1:0]     idx_c;
	logic [SZW-1:0]    sz_wide_c;
	logic signed [DW-1:0] delta_c, nsz_c, end_c, limit_c;
	logic              ext_any, low_ext, place_full, place_ext2;
	logic signed [PW-1:0] start_z, gap_c, left_c, next_base_c;
	logic              fits_c, better_c, take_c, move_c, over_lim, nonpos_c, has_next;

	logic              fin_c;
	res_t              res_c;
	logic              slot_we, size_only;
	logic [SI-1:0]     wa;
	logic [OB-1:0]     wd_start, wd_size;
	logic              wd_ext;

	always_comb begin
		unique case (state_q)
			S_SCAN:   rd_addr = i_q;
			S_SHIFT:  rd_addr = j_q - 1'b1;
			S_GROW_A: rd_addr = k_q;
			S_GROW_B: rd_addr = k_q + 1'b1;
			default:  rd_addr = SI'(slot_index);
		endcase
	end

	assign rd_start = start_q[rd_addr];
	assign rd_size  = size_q[rd_addr];
	assign rd_valid = valid_q[rd_addr];
	assign rd_ext   = ext_q[rd_addr];

	// request decode
	always_comb begin
		unique case (size_unit)
			UNIT_KIB: sh_c = 5'(KIB_SHIFT);
			UNIT_MIB: sh_c = 5'(MIB_SHIFT);
			default:  sh_c = '0;
		endcase
	end

	assign unit_ok   = (size_unit == UNIT_B) || (size_unit == UNIT_KIB) || (size_unit == UNIT_MIB);
	assign amt_pos   = !amount[AMT_W-1] && (amount != '0);
	assign sz_wide_c = SZW'(amount[AMT_W-2:0]) << sh_c;
	assign over_c    = (sz_wide_c >> OB) != '0;
	assign delta_c   = DW'(amount) <<< sh_c;
	assign idx_ok    = 32'(slot_index) < 32'(SLOTS);
	assign idx_c     = SI'(slot_index);

	// table scan checks: a full table is reported unless the request is extended and a slot
	// below the last one already holds an extended region
	assign ext_any    = |(valid_q & ext_q);
	assign low_ext    = |(valid_q[SLOTS-2:0] & ext_q[SLOTS-2:0]);
	assign place_full = (&valid_q) && !(region_kind && low_ext);
	assign place_ext2 = region_kind && ext_any;

	// gap unit
	assign start_z     = $signed(PW'(rd_start));
	assign gap_c       = rd_valid ? (start_z - base_q) : ($signed(PW'(disk_q)) - base_q);
	assign left_c      = gap_c - $signed(PW'(sz_q));
	assign fits_c      = !left_c[PW-1];
	assign better_c    = !found_q ||
	                     ((fit_q == FIT_BEST) && (left_c < best_left_q)) ||
	                     ((fit_q == FIT_WORST) && (left_c > best_left_q));
	assign take_c      = fits_c && better_c;
	assign next_base_c = start_z + $signed(PW'(rd_size));

	// insertion: move the region below up while it starts after the new one
	assign move_c = (j_q != '0) && (rd_start > best_start_q);

	// grow unit
	assign nsz_c    = $signed(DW'(rd_size)) + delta_q;
	assign nonpos_c = nsz_c[DW-1] || (nsz_c == '0);
	assign end_c    = $signed(DW'(gstart_q)) + nsz_q;
	assign has_next = (k_q != LAST_IDX) && rd_valid;
	assign limit_c  = has_next ? $signed(DW'(rd_start)) : $signed(DW'(disk_q));
	assign over_lim = end_c > limit_c;

	always_comb begin
		state_d   = state_q;
		fin_c     = 1'b0;
		res_c     = res_fail(ST_OK);
		slot_we   = 1'b0;
		size_only = 1'b0;
		wa        = j_q;
		wd_start  = best_start_q;
		wd_size   = sz_q;
		wd_ext    = kind_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (action)
						ACT_PLACE: begin
							fin_c = 1'b1;
							if (!amt_pos || !unit_ok || over_c) begin
								res_c = res_fail(ST_BAD_SIZE);
							end else if (place_full) begin
								res_c = res_fail(ST_FULL);
							end else if (place_ext2) begin
								res_c = res_fail(ST_EXT_TWICE);
							end else begin
								fin_c   = 1'b0;
								state_d = S_SCAN;
							end
						end
						ACT_GROW: begin
							fin_c = 1'b1;
							if (!unit_ok) begin
								res_c = res_fail(ST_BAD_SIZE);
							end else if (!idx_ok || !rd_valid) begin
								res_c = res_fail(ST_NO_SLOT);
							end else begin
								fin_c   = 1'b0;
								state_d = S_GROW_A;
							end
						end
						ACT_READ: begin
							fin_c = 1'b1;
							if (!idx_ok) begin
								res_c = res_fail(ST_NO_SLOT);
							end else begin
								res_c = pack_res(ST_OK, idx_c, rd_start, rd_size, rd_valid, rd_ext);
							end
						end
						default: begin
							fin_c = 1'b1;
							res_c = res_fail(ST_UNCHANGED);
						end
					endcase
				end
			end
			S_SCAN: begin
				// first empty slot ends the table: the last gap runs to the disk end
				if (!rd_valid) begin
					if (!(found_q || fits_c)) begin
						fin_c   = 1'b1;
						res_c   = res_fail(ST_NO_SPACE);
						state_d = S_IDLE;
					end else begin
						state_d = S_SHIFT;
					end
				end
			end
			S_SHIFT: begin
				slot_we = 1'b1;
				if (move_c) begin
					wd_start = rd_start;
					wd_size  = rd_size;
					wd_ext   = rd_ext;
				end else begin
					fin_c   = 1'b1;
					res_c   = pack_res(ST_OK, j_q, best_start_q, sz_q, 1'b1, kind_q);
					state_d = S_IDLE;
				end
			end
			S_GROW_A: begin
				if (nonpos_c) begin
					fin_c   = 1'b1;
					res_c   = pack_res(ST_UNCHANGED, k_q, rd_start, rd_size, 1'b1, rd_ext);
					state_d = S_IDLE;
				end else begin
					state_d = S_GROW_B;
				end
			end
			S_GROW_B: begin
				fin_c   = 1'b1;
				state_d = S_IDLE;
				if (over_lim) begin
					res_c = res_fail(ST_OVER);
				end else begin
					slot_we   = 1'b1;
					size_only = 1'b1;
					wa        = k_q;
					wd_size   = nsz_q[OB-1:0];
					res_c     = pack_res(ST_OK, k_q, gstart_q, nsz_q[OB-1:0], 1'b1, ext_q[k_q]);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			valid_q <= '0;
			disk_q  <= DISK_SIZE_RST;
			fit_q   <= FIT_MODE_RST;
			tbase_q <= TABLE_BASE_RST;
		end else begin
			state_q <= state_d;
			done_q  <= fin_c;
			if (slot_we && !size_only) begin
				valid_q[wa] <= 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_DISK_SIZE:  disk_q  <= cfg_data;
					REG_FIT_MODE:   fit_q   <= cfg_data[CODE_W-1:0];
					REG_TABLE_BASE: tbase_q <= cfg_data[BASE_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// table contents and working registers
	always_ff @(posedge clk) begin
		if (slot_we) begin
			size_q[wa] <= wd_size;
			if (!size_only) begin
				start_q[wa] <= wd_start;
				ext_q[wa]   <= wd_ext;
			end
		end
		if (fin_c) begin
			res_q <= res_c;
		end
		unique case (state_q)
			S_IDLE: begin
				sz_q    <= sz_wide_c[OB-1:0];
				kind_q  <= region_kind;
				base_q  <= $signed(PW'(tbase_q));
				found_q <= 1'b0;
				i_q     <= '0;
				delta_q <= delta_c;
				k_q     <= idx_c;
			end
			S_SCAN: begin
				if (take_c) begin
					found_q      <= 1'b1;
					best_left_q  <= left_c;
					best_start_q <= base_q[OB-1:0];
				end
				if (rd_valid) begin
					base_q <= next_base_c;
					i_q    <= i_q + 1'b1;
				end else begin
					j_q <= i_q;
				end
			end
			S_SHIFT: begin
				if (move_c) begin
					j_q <= j_q - 1'b1;
				end
			end
			S_GROW_A: begin
				nsz_q    <= nsz_c;
				gstart_q <= rd_start;
			end
			default: begin
			end
		endcase
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign status          = res_q.status;
	assign result_slot     = res_q.slot;
	assign region_start    = res_q.start;
	assign region_size     = res_q.size;
	assign region_valid    = res_q.valid;
	assign region_extended = res_q.ext;

endmodule
